FILE: hw/rtl/cbsm_pkg.sv
`default_nettype none
package cbsm_pkg;

   // Fixed sizes
   localparam int unsigned ROM_BYTES = 1048576;
   localparam int unsigned RAM_BYTES = 256;
   localparam int unsigned RAM_AW    = $clog2(RAM_BYTES);
   localparam int unsigned OFF_W     = 20;

   // Bank offset sums stay below 2**SUM_W (127 * 8K + 64 * 8K)
   localparam int unsigned SUM_W     = 21;

   // Reciprocal for the offset reduction modulo ROM_BYTES
   localparam int unsigned RECIP_K   = SUM_W + $clog2(ROM_BYTES);
   localparam int unsigned RECIP_W   = SUM_W + 1;
   localparam int unsigned PROD_W    = SUM_W + RECIP_W;
   localparam logic [63:0] RECIP_M64 =
      ((64'd1 << RECIP_K) + 64'(ROM_BYTES) - 64'd1) / 64'(ROM_BYTES);
   localparam logic [RECIP_W-1:0] RECIP_M = RECIP_M64[RECIP_W-1:0];
   localparam logic [SUM_W-1:0]   ROM_D   = SUM_W'(ROM_BYTES);

   // Command codes
   localparam logic [2:0] CMD_IO1_WR = 3'd0;
   localparam logic [2:0] CMD_IO1_RD = 3'd1;
   localparam logic [2:0] CMD_IO2_WR = 3'd2;
   localparam logic [2:0] CMD_IO2_RD = 3'd3;
   localparam logic [2:0] CMD_RESET  = 3'd4;
   localparam logic [2:0] CMD_PORT   = 3'd5;

   // Cartridge types
   localparam logic [2:0] TYPE_DATA_BANK = 3'd0;
   localparam logic [2:0] TYPE_16K_LOCK  = 3'd1;
   localparam logic [2:0] TYPE_ADDR_WR   = 3'd2;
   localparam logic [2:0] TYPE_ADDR_RD   = 3'd3;
   localparam logic [2:0] TYPE_BANK7     = 3'd4;
   localparam logic [2:0] TYPE_FLASH     = 3'd5;

   // Configuration register indexes
   localparam logic [1:0] CSR_CART_TYPE   = 2'd0;
   localparam logic [1:0] CSR_GAME_INIT   = 2'd1;
   localparam logic [1:0] CSR_EXROM_INIT  = 2'd2;

   // Flash type register addresses
   localparam logic [7:0] FLASH_REG_BANK  = 8'h00;
   localparam logic [7:0] FLASH_REG_LINES = 8'h02;

   // Region sources
   localparam logic [1:0] SRC_RAM    = 2'd0;
   localparam logic [1:0] SRC_BASIC  = 2'd1;
   localparam logic [1:0] SRC_KERNAL = 2'd2;
   localparam logic [1:0] SRC_ROM    = 2'd3;

   // Read data selection
   localparam logic [1:0] RD_ZERO = 2'd0;
   localparam logic [1:0] RD_BUS  = 2'd1;
   localparam logic [1:0] RD_RAM  = 2'd2;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] io_addr;
      logic [7:0] wr_data;
      logic [7:0] open_bus;
      logic [1:0] port_dir;
      logic [1:0] port_out;
   } req_type;

   typedef struct packed {
      logic [7:0]       rd_data;
      logic             exrom_n;
      logic             game_n;
      logic [1:0]       lo_src;
      logic [OFF_W-1:0] lo_offset;
      logic [1:0]       mid_src;
      logic [OFF_W-1:0] mid_offset;
      logic [1:0]       top_src;
      logic [OFF_W-1:0] top_offset;
   } rsp_type;

   // Cartridge state after a request
   typedef struct packed {
      logic [2:0] cart_type;
      logic [6:0] bank;
      logic       exrom;
      logic       game;
   } cart_state_type;

   typedef struct packed {
      logic [1:0] lo;
      logic [1:0] mid;
      logic [1:0] top;
   } map_type;

   // Decode {exrom, game, port[1:0]} into the three region sources
   function automatic map_type map_decode(input logic [3:0] sel);
      map_type m;
      m = '{lo: SRC_RAM, mid: SRC_RAM, top: SRC_RAM};
      case (sel)
         4'hF: begin
            m.mid = SRC_BASIC;
            m.top = SRC_KERNAL;
         end
         4'hE, 4'h6: begin
            m.top = SRC_KERNAL;
         end
         4'hB, 4'hA, 4'h9, 4'h8: begin
            m.lo  = SRC_ROM;
            m.top = SRC_ROM;
         end
         4'h7: begin
            m.lo  = SRC_ROM;
            m.mid = SRC_BASIC;
            m.top = SRC_KERNAL;
         end
         4'h3: begin
            m.lo  = SRC_ROM;
            m.mid = SRC_ROM;
            m.top = SRC_KERNAL;
         end
         4'h2: begin
            m.mid = SRC_ROM;
            m.top = SRC_KERNAL;
         end
         default: begin
            m = '{lo: SRC_RAM, mid: SRC_RAM, top: SRC_RAM};
         end
      endcase
      return m;
   endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/cbsm_ram.sv
`default_nettype none
module cbsm_ram
   import cbsm_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              rd_en,
   input  wire logic              wr_en,
   input  wire logic [RAM_AW-1:0] addr,
   input  wire logic [7:0]        wr_data,
   output logic      [7:0]        rd_data
);

   logic [7:0]           mem [RAM_BYTES];
   logic [RAM_BYTES-1:0] valid_ff;
   logic [7:0]           q_ff;
   logic                 q_valid_ff;

   // Write the byte and mark it valid
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[addr] <= 1'b1;
      end
   end

   // Registered read; an unwritten entry reads as zero
   always_ff @(posedge clock) begin
      if (rd_en) begin
         q_ff       <= mem[addr];
         q_valid_ff <= valid_ff[addr];
      end
   end

   assign rd_data = q_valid_ff ? q_ff : 8'h00;

endmodule
`default_nettype wire

FILE: hw/rtl/cbsm_state.sv
`default_nettype none
module cbsm_state
   import cbsm_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           csr_wr_en,
   input  wire logic [1:0]     csr_index,
   input  wire logic [2:0]     csr_wr_data,
   input  wire logic           accept,
   input  wire req_type        req,
   output cart_state_type      next_state
);

   logic [2:0] type_ff, type_in;
   logic       game_init_ff, game_init_in;
   logic       exrom_init_ff, exrom_init_in;
   logic [6:0] bank_ff, bank_in;
   logic       exrom_ff, exrom_in;
   logic       game_ff, game_in;
   logic       lock_ff, lock_in;

   // State after the current request
   logic [6:0] bank_upd;
   logic       exrom_upd, game_upd, lock_upd;

   always_comb begin
      bank_upd  = bank_ff;
      exrom_upd = exrom_ff;
      game_upd  = game_ff;
      lock_upd  = lock_ff;
      case (req.cmd)
         CMD_IO1_WR: begin
            if (type_ff == TYPE_DATA_BANK) begin
               bank_upd = {1'b0, req.wr_data[5:0]};
            end else if (type_ff == TYPE_ADDR_WR) begin
               bank_upd = {1'b0, req.io_addr[5:0]};
            end else if (type_ff == TYPE_BANK7) begin
               bank_upd  = req.wr_data[6:0];
               exrom_upd = req.wr_data[7];
            end else if (type_ff == TYPE_FLASH) begin
               if (req.io_addr == FLASH_REG_BANK) begin
                  bank_upd = {1'b0, req.wr_data[5:0]};
               end else if (req.io_addr == FLASH_REG_LINES) begin
                  exrom_upd = ~req.wr_data[1];
                  game_upd  = req.wr_data[2] & ~req.wr_data[0];
               end
            end
         end
         CMD_IO1_RD: begin
            if (type_ff == TYPE_ADDR_WR) begin
               exrom_upd = 1'b1;
            end else if (type_ff == TYPE_ADDR_RD) begin
               bank_upd = {3'b000, req.io_addr[3:0]};
            end
         end
         CMD_IO2_WR: begin
            if (type_ff == TYPE_16K_LOCK && !lock_ff) begin
               bank_upd  = {5'b00000, req.wr_data[1:0]};
               exrom_upd = req.wr_data[2];
               game_upd  = req.wr_data[2];
               lock_upd  = req.wr_data[3];
            end
         end
         CMD_RESET: begin
            bank_upd = '0;
            if (type_ff == TYPE_16K_LOCK) begin
               exrom_upd = 1'b0;
               game_upd  = 1'b0;
               lock_upd  = 1'b0;
            end else if (type_ff == TYPE_BANK7) begin
               exrom_upd = 1'b0;
            end
         end
         default: begin
            bank_upd = bank_ff;
         end
      endcase
   end

   // Configuration writes reload the lines; requests apply their update
   always_comb begin
      type_in       = type_ff;
      game_init_in  = game_init_ff;
      exrom_init_in = exrom_init_ff;
      bank_in       = bank_ff;
      exrom_in      = exrom_ff;
      game_in       = game_ff;
      lock_in       = lock_ff;
      if (csr_wr_en && csr_index <= CSR_EXROM_INIT) begin
         case (csr_index)
            CSR_CART_TYPE:  type_in       = csr_wr_data;
            CSR_GAME_INIT:  game_init_in  = csr_wr_data[0];
            CSR_EXROM_INIT: exrom_init_in = csr_wr_data[0];
            default:        type_in       = type_ff;
         endcase
         bank_in  = '0;
         lock_in  = 1'b0;
         exrom_in = (type_in == TYPE_FLASH) ? exrom_init_in : 1'b0;
         if (type_in == TYPE_DATA_BANK || type_in == TYPE_FLASH) begin
            game_in = game_init_in;
         end else if (type_in == TYPE_16K_LOCK) begin
            game_in = 1'b0;
         end else begin
            game_in = 1'b1;
         end
      end else if (accept) begin
         bank_in  = bank_upd;
         exrom_in = exrom_upd;
         game_in  = game_upd;
         lock_in  = lock_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         type_ff       <= TYPE_DATA_BANK;
         game_init_ff  <= 1'b1;
         exrom_init_ff <= 1'b0;
         bank_ff       <= '0;
         exrom_ff      <= 1'b0;
         game_ff       <= 1'b1;
         lock_ff       <= 1'b0;
      end else begin
         type_ff       <= type_in;
         game_init_ff  <= game_init_in;
         exrom_init_ff <= exrom_init_in;
         bank_ff       <= bank_in;
         exrom_ff      <= exrom_in;
         game_ff       <= game_in;
         lock_ff       <= lock_in;
      end
   end

   assign next_state = '{cart_type: type_ff, bank: bank_upd,
                         exrom: exrom_upd, game: game_upd};

endmodule
`default_nettype wire

FILE: hw/rtl/cbsm_mod.sv
`default_nettype none
module cbsm_mod
   import cbsm_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             adv_mul,
   input  wire logic             adv_sub,
   input  wire logic [SUM_W-1:0] sum,
   output logic      [OFF_W-1:0] offset
);

   logic [SUM_W-1:0]  n_ff;
   logic [SUM_W-1:0]  q_ff;
   logic [OFF_W-1:0]  r_ff;
   logic [PROD_W-1:0] prod;
   logic [PROD_W-1:0] prod_shift;
   logic [2*SUM_W-1:0] qd;
   logic [SUM_W-1:0]  rem;
   logic [SUM_W-1:0]  rem_fix;

   // Estimate the quotient by the reciprocal
   assign prod       = PROD_W'(sum) * PROD_W'(RECIP_M);
   assign prod_shift = prod >> RECIP_K;

   always_ff @(posedge clock) begin
      if (adv_mul) begin
         n_ff <= sum;
         q_ff <= prod_shift[SUM_W-1:0];
      end
   end

   // Subtract the quotient multiple and correct once
   assign qd      = (2*SUM_W)'(q_ff) * (2*SUM_W)'(ROM_D);
   assign rem     = n_ff - qd[SUM_W-1:0];
   assign rem_fix = (rem >= ROM_D) ? rem - ROM_D : rem;

   always_ff @(posedge clock) begin
      if (adv_sub) begin
         r_ff <= rem_fix[OFF_W-1:0];
      end
   end

   assign offset = r_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/cartridge_bank_switch_map_core.sv
`default_nettype none
// Banked cartridge ROM controller. Each request (an I/O-page access, a
// cartridge reset or a CPU port update) updates the bank number, EXROM and
// GAME lines and I/O lock, and returns one response with the read data, the
// lines and the source and ROM offset of the 8000, A000 and E000 regions.
// One request is taken every cycle unless stalled. The pipeline holds the
// registered read of the 256-byte scratch RAM and the two-stage reduction
// of bank offsets modulo the ROM size. After reset the scratch RAM reads as
// zero at once, with no clearing pass. The user must write configuration
// only while no request is in flight; the block does not enforce it.
module cartridge_bank_switch_map_core
   import cbsm_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_wr_en,
   input  wire logic [1:0] csr_index,
   input  wire logic [2:0] csr_wr_data,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire req_type    req_data,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output rsp_type         rsp_data
);

   logic           en1, en2, en3;
   logic           accept;
   logic           v1_ff, v2_ff, v3_ff;
   cart_state_type st;
   map_type        map_in;
   logic [1:0]     port;
   logic [SUM_W-1:0] base, high_add;
   logic [7:0]     ram_rd;

   // Stage 1 payload
   logic [1:0]       s1_rd_sel_ff;
   logic [7:0]       s1_bus_ff;
   logic             s1_exrom_ff, s1_game_ff;
   map_type          s1_map_ff;
   logic [SUM_W-1:0] s1_base_ff, s1_high_ff;
   // Stage 2 payload
   logic [7:0]       s2_rd_ff;
   logic             s2_exrom_ff, s2_game_ff;
   map_type          s2_map_ff;
   // Output stage payload
   logic [7:0]       s3_rd_ff;
   logic             s3_exrom_ff, s3_game_ff;
   map_type          s3_map_ff;
   logic [OFF_W-1:0] off_base, off_high;

   // Advance each stage when the next one is free or moving
   assign en3       = !v3_ff || !rsp_stall;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req_stall = !en1;
   assign accept    = req_valid && en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   cbsm_state u_state (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .accept      (accept),
      .req         (req_data),
      .next_state  (st)
   );

   cbsm_ram u_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .wr_en   (accept && req_data.cmd == CMD_IO2_WR && st.cart_type == TYPE_FLASH),
      .addr    (req_data.io_addr[RAM_AW-1:0]),
      .wr_data (req_data.wr_data),
      .rd_data (ram_rd)
   );

   // Decode the map and the bank offsets from the updated state
   assign port   = ~req_data.port_dir | req_data.port_out;
   assign map_in = map_decode({st.exrom, st.game, port});
   assign base   = (st.cart_type == TYPE_16K_LOCK) ?
                   SUM_W'({st.bank, 14'h0000}) : SUM_W'({st.bank, 13'h0000});

   always_comb begin
      if (st.cart_type == TYPE_16K_LOCK) begin
         high_add = SUM_W'(32'h2000);
      end else if (st.cart_type inside {[TYPE_ADDR_WR:TYPE_FLASH]}) begin
         high_add = SUM_W'(32'd64 * 32'h2000);
      end else begin
         high_add = '0;
      end
   end

   // Capture the request into stage 1
   always_ff @(posedge clock) begin
      if (en1) begin
         if (req_data.cmd == CMD_IO2_RD && st.cart_type == TYPE_FLASH) begin
            s1_rd_sel_ff <= RD_RAM;
         end else if (req_data.cmd inside {CMD_IO1_RD, CMD_IO2_RD}) begin
            s1_rd_sel_ff <= RD_BUS;
         end else begin
            s1_rd_sel_ff <= RD_ZERO;
         end
         s1_bus_ff   <= req_data.open_bus;
         s1_exrom_ff <= st.exrom;
         s1_game_ff  <= st.game;
         s1_map_ff   <= map_in;
         s1_base_ff  <= base;
         s1_high_ff  <= base + high_add;
      end
   end

   // Resolve the read data in stage 2
   always_ff @(posedge clock) begin
      if (en2) begin
         case (s1_rd_sel_ff)
            RD_RAM:  s2_rd_ff <= ram_rd;
            RD_BUS:  s2_rd_ff <= s1_bus_ff;
            default: s2_rd_ff <= 8'h00;
         endcase
         s2_exrom_ff <= s1_exrom_ff;
         s2_game_ff  <= s1_game_ff;
         s2_map_ff   <= s1_map_ff;
      end
   end

   cbsm_mod u_mod_base (
      .clock   (clock),
      .adv_mul (en2),
      .adv_sub (en3),
      .sum     (s1_base_ff),
      .offset  (off_base)
   );

   cbsm_mod u_mod_high (
      .clock   (clock),
      .adv_mul (en2),
      .adv_sub (en3),
      .sum     (s1_high_ff),
      .offset  (off_high)
   );

   // Hold the response in the output stage
   always_ff @(posedge clock) begin
      if (en3) begin
         s3_rd_ff    <= s2_rd_ff;
         s3_exrom_ff <= s2_exrom_ff;
         s3_game_ff  <= s2_game_ff;
         s3_map_ff   <= s2_map_ff;
      end
   end

   assign rsp_valid = v3_ff;

   // Offsets read as zero unless the region maps cartridge ROM
   always_comb begin
      rsp_data.rd_data    = s3_rd_ff;
      rsp_data.exrom_n    = s3_exrom_ff;
      rsp_data.game_n     = s3_game_ff;
      rsp_data.lo_src     = s3_map_ff.lo;
      rsp_data.lo_offset  = (s3_map_ff.lo == SRC_ROM) ? off_base : '0;
      rsp_data.mid_src    = s3_map_ff.mid;
      rsp_data.mid_offset = (s3_map_ff.mid == SRC_ROM) ? off_high : '0;
      rsp_data.top_src    = s3_map_ff.top;
      rsp_data.top_offset = (s3_map_ff.top == SRC_ROM) ? off_high : '0;
   end

endmodule
`default_nettype wire

FILE: test/cartridge_bank_switch_map_core_test.sv
`timescale 1ns / 1ps
module cartridge_bank_switch_map_core_test;
   import cbsm_pkg::*;

   localparam int CYCLE_LIMIT   = 600000;
   localparam int RANDOM_ITEMS  = 1300;
   localparam int SETTLE_CYCLES = 6;

   // Codes beyond the defined ones, which the block must still handle
   localparam logic [2:0] CMD_SPARE_6  = 3'd6;
   localparam logic [2:0] CMD_SPARE_7  = 3'd7;
   localparam logic [2:0] TYPE_SPARE_6 = 3'd6;
   localparam logic [2:0] TYPE_SPARE_7 = 3'd7;
   localparam logic [1:0] CSR_SPARE    = 2'd3;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       csr_wr_en   = 1'b0;
   logic [1:0] csr_index   = '0;
   logic [2:0] csr_wr_data = '0;
   logic       req_valid   = 1'b0;
   logic       req_stall;
   req_type    req_data    = '0;
   logic       rsp_valid;
   logic       rsp_stall   = 1'b0;
   rsp_type    rsp_data;

   // Shadow copy of the cartridge state and configuration
   logic [2:0] shadow_type       = TYPE_DATA_BANK;
   logic       shadow_game_init  = 1'b1;
   logic       shadow_exrom_init = 1'b0;
   logic [6:0] shadow_bank;
   logic       shadow_exrom;
   logic       shadow_game;
   logic       shadow_lock;
   logic [7:0] shadow_ram [RAM_BYTES];

   rsp_type expected_rsp_q [$];
   rsp_type want_rsp;
   int      errors         = 0;
   int      requests_sent  = 0;
   int      responses_seen = 0;
   int      cycle_count    = 0;
   int      stall_left     = 0;
   int      stall_len;
   bit      no_idle        = 1'b0;

   cartridge_bank_switch_map_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   always #6 clock = ~clock;

   // Mostly short gaps, now and then a long one
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Load the lines that the current cart type starts with
   function automatic void load_type_defaults();
      shadow_exrom = 1'b0;
      shadow_game  = 1'b1;
      case (shadow_type)
         TYPE_DATA_BANK: shadow_game = shadow_game_init;
         TYPE_16K_LOCK:  shadow_game = 1'b0;
         TYPE_FLASH: begin
            shadow_exrom = shadow_exrom_init;
            shadow_game  = shadow_game_init;
         end
         default: ;
      endcase
      shadow_bank = '0;
      shadow_lock = 1'b0;
   endfunction

   function automatic logic [OFF_W-1:0] rom_offset(input logic [31:0] base,
                                                   input logic [31:0] add);
      logic [31:0] sum;
      sum = (base + add) % ROM_BYTES;
      return sum[OFF_W-1:0];
   endfunction

   // Advance the shadow state by one request and build its response
   function automatic rsp_type predict_cart_response(input req_type r);
      rsp_type          p;
      logic [1:0]       port;
      logic [3:0]       sel;
      logic [31:0]      base;
      logic [31:0]      hi_add;
      logic [OFF_W-1:0] lo_off;
      logic [OFF_W-1:0] hi_off;
      p    = '0;
      port = ~r.port_dir | r.port_out;
      if (r.cmd == CMD_IO1_RD || r.cmd == CMD_IO2_RD) p.rd_data = r.open_bus;

      case (r.cmd)
         CMD_IO1_WR: begin
            case (shadow_type)
               TYPE_DATA_BANK: shadow_bank = {1'b0, r.wr_data[5:0]};
               TYPE_ADDR_WR:   shadow_bank = {1'b0, r.io_addr[5:0]};
               TYPE_BANK7: begin
                  shadow_bank  = r.wr_data[6:0];
                  shadow_exrom = r.wr_data[7];
               end
               TYPE_FLASH: begin
                  if (r.io_addr == FLASH_REG_BANK) begin
                     shadow_bank = {1'b0, r.wr_data[5:0]};
                  end else if (r.io_addr == FLASH_REG_LINES) begin
                     shadow_exrom = ~r.wr_data[1];
                     shadow_game  = r.wr_data[2] ? ~r.wr_data[0] : 1'b0;
                  end
               end
               default: ;
            endcase
         end
         CMD_IO1_RD: begin
            if (shadow_type == TYPE_ADDR_WR) shadow_exrom = 1'b1;
            else if (shadow_type == TYPE_ADDR_RD) shadow_bank = {3'b000, r.io_addr[3:0]};
         end
         CMD_IO2_WR: begin
            if (shadow_type == TYPE_16K_LOCK && !shadow_lock) begin
               shadow_bank  = {5'b00000, r.wr_data[1:0]};
               shadow_exrom = r.wr_data[2];
               shadow_game  = r.wr_data[2];
               shadow_lock  = r.wr_data[3];
            end else if (shadow_type == TYPE_FLASH) begin
               shadow_ram[r.io_addr] = r.wr_data;
            end
         end
         CMD_IO2_RD: begin
            if (shadow_type == TYPE_FLASH) p.rd_data = shadow_ram[r.io_addr];
         end
         CMD_RESET: begin
            shadow_bank = '0;
            if (shadow_type == TYPE_16K_LOCK) begin
               shadow_exrom = 1'b0;
               shadow_game  = 1'b0;
               shadow_lock  = 1'b0;
            end else if (shadow_type == TYPE_BANK7) begin
               shadow_exrom = 1'b0;
            end
         end
         default: ;
      endcase

      // Bank base and the extra step to the high ROM half
      base = 32'(shadow_bank) * ((shadow_type == TYPE_16K_LOCK) ? 32'h4000 : 32'h2000);
      if (shadow_type == TYPE_16K_LOCK) hi_add = 32'h2000;
      else if (shadow_type >= TYPE_ADDR_WR && shadow_type <= TYPE_FLASH) hi_add = 64 * 32'h2000;
      else hi_add = '0;
      lo_off = rom_offset(base, 32'd0);
      hi_off = rom_offset(base, hi_add);

      // Decode {exrom, game, port} into region sources
      sel = {shadow_exrom, shadow_game, port};
      p.lo_src  = SRC_RAM;
      p.mid_src = SRC_RAM;
      p.top_src = SRC_RAM;
      case (sel)
         4'hF: begin
            p.mid_src = SRC_BASIC;
            p.top_src = SRC_KERNAL;
         end
         4'hE, 4'h6: p.top_src = SRC_KERNAL;
         4'hB, 4'hA, 4'h9, 4'h8: begin
            p.lo_src     = SRC_ROM;
            p.lo_offset  = lo_off;
            p.top_src    = SRC_ROM;
            p.top_offset = hi_off;
         end
         4'h7: begin
            p.lo_src    = SRC_ROM;
            p.lo_offset = lo_off;
            p.mid_src   = SRC_BASIC;
            p.top_src   = SRC_KERNAL;
         end
         4'h3: begin
            p.lo_src     = SRC_ROM;
            p.lo_offset  = lo_off;
            p.mid_src    = SRC_ROM;
            p.mid_offset = hi_off;
            p.top_src    = SRC_KERNAL;
         end
         4'h2: begin
            p.mid_src    = SRC_ROM;
            p.mid_offset = hi_off;
            p.top_src    = SRC_KERNAL;
         end
         default: ;
      endcase
      p.exrom_n = shadow_exrom;
      p.game_n  = shadow_game;
      return p;
   endfunction

   function automatic void check_field(input string name, input logic [OFF_W-1:0] want,
                                       input logic [OFF_W-1:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      end
   endfunction

   // Compare each accepted response with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         responses_seen++;
         if (expected_rsp_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected response, expected none actual %h", $time, rsp_data);
         end else begin
            want_rsp = expected_rsp_q.pop_front();
            check_field("rd_data", OFF_W'(want_rsp.rd_data), OFF_W'(rsp_data.rd_data));
            check_field("exrom_n", OFF_W'(want_rsp.exrom_n), OFF_W'(rsp_data.exrom_n));
            check_field("game_n", OFF_W'(want_rsp.game_n), OFF_W'(rsp_data.game_n));
            check_field("lo_src", OFF_W'(want_rsp.lo_src), OFF_W'(rsp_data.lo_src));
            check_field("lo_offset", want_rsp.lo_offset, rsp_data.lo_offset);
            check_field("mid_src", OFF_W'(want_rsp.mid_src), OFF_W'(rsp_data.mid_src));
            check_field("mid_offset", want_rsp.mid_offset, rsp_data.mid_offset);
            check_field("top_src", OFF_W'(want_rsp.top_src), OFF_W'(rsp_data.top_src));
            check_field("top_offset", want_rsp.top_offset, rsp_data.top_offset);
         end
      end
   end

   // Stall the response side in random bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         stall_len = idle_length();
         if (stall_len > 0) begin
            stall_left = stall_len - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Guard against a hang
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d responses outstanding", $time, expected_rsp_q.size());
         $display("FAIL cartridge_bank_switch_map_core");
         $finish;
      end
   end

   // Hold valid high back to back when no gap is drawn
   task automatic send_request(input req_type r);
      int gap;
      gap = idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      expected_rsp_q.push_back(predict_cart_response(r));
      requests_sent++;
   endtask

   // Write one register once every request has drained
   task automatic csr_write(input logic [1:0] index, input logic [2:0] value);
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (index)
         CSR_CART_TYPE:  shadow_type       = value;
         CSR_GAME_INIT:  shadow_game_init  = value[0];
         CSR_EXROM_INIT: shadow_exrom_init = value[0];
         default: ;
      endcase
      if (index != CSR_SPARE) load_type_defaults();
   endtask

   task automatic configure(input logic [2:0] kind, input logic [2:0] game_val,
                            input logic [2:0] exrom_val);
      csr_write(CSR_GAME_INIT, game_val);
      csr_write(CSR_EXROM_INIT, exrom_val);
      csr_write(CSR_CART_TYPE, kind);
   endtask

   function automatic req_type bus_event(input logic [2:0] cmd, input logic [7:0] addr,
                                         input logic [7:0] data, input logic [7:0] bus,
                                         input logic [1:0] dir, input logic [1:0] out);
      req_type r;
      r.cmd      = cmd;
      r.io_addr  = addr;
      r.wr_data  = data;
      r.open_bus = bus;
      r.port_dir = dir;
      r.port_out = out;
      return r;
   endfunction

   // Random request, weighted toward the accesses the current type reacts to
   function automatic req_type random_request();
      req_type r;
      int      pick;
      r.io_addr  = 8'($urandom);
      r.wr_data  = 8'($urandom);
      r.open_bus = 8'($urandom);
      r.port_dir = 2'($urandom);
      r.port_out = 2'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
         r.cmd = $urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7;
      end else if (pick < 40) begin
         r.cmd = 3'($urandom_range(CMD_IO1_WR, CMD_PORT));
      end else begin
         case (shadow_type)
            TYPE_DATA_BANK: r.cmd = CMD_IO1_WR;
            TYPE_16K_LOCK:  r.cmd = ($urandom_range(0, 3) == 0) ? CMD_RESET : CMD_IO2_WR;
            TYPE_ADDR_WR:   r.cmd = ($urandom_range(0, 7) == 0) ? CMD_IO1_RD : CMD_IO1_WR;
            TYPE_ADDR_RD:   r.cmd = CMD_IO1_RD;
            TYPE_BANK7:     r.cmd = ($urandom_range(0, 3) == 0) ? CMD_RESET : CMD_IO1_WR;
            TYPE_FLASH: begin
               case ($urandom_range(0, 2))
                  0:       r.cmd = CMD_IO1_WR;
                  1:       r.cmd = CMD_IO2_WR;
                  default: r.cmd = CMD_IO2_RD;
               endcase
            end
            default: r.cmd = CMD_PORT;
         endcase
      end
      // Aim flash accesses at its registers and at a small RAM window
      if (shadow_type == TYPE_FLASH && $urandom_range(0, 1) == 1) begin
         if (r.cmd == CMD_IO1_WR) begin
            r.io_addr = $urandom_range(0, 1) ? FLASH_REG_BANK : FLASH_REG_LINES;
         end else begin
            r.io_addr = {4'h0, r.io_addr[3:0]};
         end
      end
      return r;
   endfunction

   // Default type right after reset: port decode and reads
   task automatic test_power_on_map();
      send_request(bus_event(CMD_PORT, 8'h00, 8'h00, 8'h00, 2'b00, 2'b00));
      send_request(bus_event(CMD_PORT, 8'hFF, 8'hFF, 8'hFF, 2'b11, 2'b00));
      send_request(bus_event(CMD_PORT, 8'h00, 8'h00, 8'h00, 2'b11, 2'b10));
      send_request(bus_event(CMD_IO2_RD, 8'hFF, 8'h00, 8'hFF, 2'b11, 2'b11));
   endtask

   task automatic test_data_bank_type();
      configure(TYPE_DATA_BANK, 3'b000, 3'b000);
      send_request(bus_event(CMD_IO1_WR, 8'h00, 8'hFF, 8'h00, 2'b00, 2'b00));
      send_request(bus_event(CMD_RESET, 8'h00, 8'h00, 8'h00, 2'b10, 2'b01));
   endtask

   // Flash registers, line control and the scratch RAM
   task automatic test_flash_type();
      configure(TYPE_FLASH, 3'b000, 3'b001);
      send_request(bus_event(CMD_IO2_RD, 8'hFF, 8'h00, 8'h5A, 2'b00, 2'b00));
      send_request(bus_event(CMD_IO2_WR, 8'hFF, 8'hFF, 8'h00, 2'b00, 2'b00));
      send_request(bus_event(CMD_IO2_RD, 8'hFF, 8'h00, 8'h00, 2'b00, 2'b00));
      send_request(bus_event(CMD_IO1_WR, FLASH_REG_LINES, 8'h07, 8'h00, 2'b00, 2'b00));
      send_request(bus_event(CMD_IO1_WR, FLASH_REG_BANK, 8'hFF, 8'h00, 2'b00, 2'b00));
      send_request(bus_event(CMD_IO1_WR, 8'h01, 8'hFF, 8'h00, 2'b00, 2'b00));
      send_request(bus_event(CMD_IO1_WR, FLASH_REG_LINES, 8'h00, 8'h00, 2'b11, 2'b01));
   endtask

   // Lock blocks further bank writes until a cartridge reset
   task automatic test_lock_type();
      configure(TYPE_16K_LOCK, 3'b001, 3'b000);
      send_request(bus_event(CMD_IO2_WR, 8'h00, 8'h0F, 8'h00, 2'b00, 2'b00));
      send_request(bus_event(CMD_IO2_WR, 8'h00, 8'h00, 8'h00, 2'b00, 2'b00));
      send_request(bus_event(CMD_RESET, 8'h00, 8'h00, 8'h00, 2'b00, 2'b00));
      send_request(bus_event(CMD_IO2_WR, 8'h00, 8'h03, 8'h00, 2'b00, 2'b00));
   endtask

   task automatic test_addr_types();
      configure(TYPE_ADDR_WR, 3'b001, 3'b001);
      send_request(bus_event(CMD_IO1_WR, 8'hFF, 8'h00, 8'h00, 2'b00, 2'b00));
      send_request(bus_event(CMD_IO1_RD, 8'h00, 8'h00, 8'hC3, 2'b00, 2'b00));
      configure(TYPE_ADDR_RD, 3'b001, 3'b000);
      send_request(bus_event(CMD_IO1_RD, 8'hFF, 8'h00, 8'h3C, 2'b00, 2'b00));
   endtask

   // Largest bank wraps past the end of the ROM
   task automatic test_bank7_type();
      configure(TYPE_BANK7, 3'b001, 3'b000);
      send_request(bus_event(CMD_IO1_WR, 8'h00, 8'hFF, 8'h00, 2'b00, 2'b00));
      send_request(bus_event(CMD_RESET, 8'h00, 8'h00, 8'h00, 2'b00, 2'b00));
   endtask

   // Undefined types, commands and register index
   task automatic test_spare_codes();
      configure(TYPE_SPARE_7, 3'b111, 3'b111);
      send_request(bus_event(CMD_IO1_WR, 8'hFF, 8'hFF, 8'h00, 2'b00, 2'b00));
      send_request(bus_event(CMD_SPARE_7, 8'hFF, 8'hFF, 8'hFF, 2'b01, 2'b10));
      configure(TYPE_SPARE_6, 3'b110, 3'b110);
      send_request(bus_event(CMD_SPARE_6, 8'h00, 8'h00, 8'h00, 2'b00, 2'b00));
      send_request(bus_event(CMD_IO2_WR, 8'h00, 8'h0F, 8'h00, 2'b00, 2'b00));
      csr_write(CSR_SPARE, 3'b111);
      send_request(bus_event(CMD_PORT, 8'h00, 8'h00, 8'h00, 2'b00, 2'b00));
   endtask

   // Phases of random requests, each under a fresh random configuration
   task automatic test_random_phases();
      int         sent;
      int         phase_len;
      logic [2:0] kind;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         no_idle = ($urandom_range(0, 5) == 0);
         if ($urandom_range(0, 9) == 0) kind = $urandom_range(0, 1) ? TYPE_SPARE_6 : TYPE_SPARE_7;
         else kind = 3'($urandom_range(TYPE_DATA_BANK, TYPE_FLASH));
         configure(kind, 3'($urandom), 3'($urandom));
         phase_len = $urandom_range(20, 80);
         repeat (phase_len) begin
            send_request(random_request());
            sent++;
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin
      for (int i = 0; i < RAM_BYTES; i++) shadow_ram[i] = 8'h00;
      load_type_defaults();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_power_on_map();
      test_data_bank_type();
      test_flash_type();
      test_lock_type();
      test_addr_types();
      test_bank7_type();
      test_spare_codes();
      test_random_phases();

      // Drain and let the pipeline settle
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Ran %0d requests and checked %0d responses across all cart types,",
               requests_sent, responses_seen);
      $display("spare codes, lock and flash RAM paths, with random stalls on both sides.");
      if (errors == 0) begin
         $display("PASS cartridge_bank_switch_map_core");
      end else begin
         $display("FAIL cartridge_bank_switch_map_core");
      end
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/cbsm_pkg.sv
hw/rtl/cbsm_ram.sv
hw/rtl/cbsm_state.sv
hw/rtl/cbsm_mod.sv
hw/rtl/cartridge_bank_switch_map_core.sv
test/cartridge_bank_switch_map_core_test.sv
